// ===== rtl/bcd_pkg.sv =====
// Shared types, constants and register codes for the BFSK crossing demodulator.
// No dependencies; the slicer, tracker, top level and bench import this package.
package bcd_pkg;

    localparam int COUNTER_WIDTH_DEF = 8;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD     = 3'd4;

    // Register values after reset
    localparam logic [7:0] MIN_PERIOD_RST     = 8'd10;
    localparam logic [7:0] MAX_PERIOD_RST     = 8'd60;
    localparam logic [7:0] LOW_THRESHOLD_RST  = 8'd40;
    localparam logic [7:0] HIGH_THRESHOLD_RST = 8'd30;
    localparam logic [7:0] BIT_PERIOD_RST     = 8'd160;

    // Frame phase codes: start, data bits 1..8, stop, idle
    localparam logic [3:0] PH_START     = 4'd0;
    localparam logic [3:0] PH_LAST_DATA = 4'd8;
    localparam logic [3:0] PH_STOP      = 4'd9;
    localparam logic [3:0] PH_IDLE      = 4'd15;

    localparam logic [7:0] TONE_HIGH_BIT = 8'h80;

    typedef struct packed {
        logic [7:0] min_period;
        logic [7:0] max_period;
        logic [7:0] low_threshold;
        logic [7:0] high_threshold;
        logic [7:0] bit_period;
    } t_cfg;

    // Tone sums and framing state shared by the bit slicer and tone tracker
    typedef struct packed {
        logic [7:0] low_sum;
        logic [7:0] high_sum;
        logic [3:0] phase;
        logic [7:0] data_shift;
        logic       armed;
    } t_frame_state;

endpackage

// ===== rtl/bcd_in_if.sv =====
// Input channel: one counter tick per request, carrying the crossing flag.
// No dependencies.
interface bcd_in_if;
    logic valid;
    logic ready;
    logic crossing;

    modport source (output valid, output crossing, input ready);
    modport sink   (input valid, input crossing, output ready);
endinterface

// ===== rtl/bcd_out_if.sv =====
// Result channel: one request per tick, with the byte strobe and the byte.
// No dependencies.
interface bcd_out_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] rx_byte;

    modport source (output valid, output byte_valid, output rx_byte, input ready);
    modport sink   (input valid, input byte_valid, input rx_byte, output ready);
endinterface

// ===== rtl/bcd_bit_slicer.sv =====
// Bit deadline service: tone decision, sum drain and frame phase advance.
// Depends on bcd_pkg.
module bcd_bit_slicer #(
    parameter int COUNTER_WIDTH = bcd_pkg::COUNTER_WIDTH_DEF
) (
    input  logic [COUNTER_WIDTH-1:0] i_tick,
    input  logic [7:0]               i_bit_period,
    input  bcd_pkg::t_frame_state    i_state,
    input  logic [COUNTER_WIDTH-1:0] i_deadline,
    output bcd_pkg::t_frame_state    o_state,
    output logic [COUNTER_WIDTH-1:0] o_deadline,
    output logic                     o_byte_valid,
    output logic [7:0]               o_rx_byte
);
    import bcd_pkg::*;

    logic high_tone;

    always_comb begin
        o_state      = i_state;
        o_deadline   = i_deadline;
        o_byte_valid = 1'b0;
        o_rx_byte    = '0;
        high_tone    = 1'b0;
        if (i_state.armed && (i_tick == i_deadline)) begin
            o_deadline = i_deadline + COUNTER_WIDTH'(i_bit_period);
            // The larger sum wins (low on a tie) and is drained by one bit period, saturating at zero
            if (i_state.high_sum > i_state.low_sum) begin
                high_tone        = 1'b1;
                o_state.high_sum = (i_state.high_sum >= i_bit_period) ?
                                   i_state.high_sum - i_bit_period : '0;
            end else begin
                o_state.low_sum = (i_state.low_sum >= i_bit_period) ?
                                  i_state.low_sum - i_bit_period : '0;
            end
            priority if (i_state.phase == PH_START) begin
                if (!high_tone) begin
                    o_state.phase = i_state.phase + 4'd1;
                end else begin
                    o_state.phase = PH_IDLE;
                    o_state.armed = 1'b0;
                end
            end else if (i_state.phase <= PH_LAST_DATA) begin
                o_state.data_shift = (i_state.data_shift >> 1) |
                                     (high_tone ? TONE_HIGH_BIT : 8'h00);
                o_state.phase      = i_state.phase + 4'd1;
            end else if (i_state.phase == PH_STOP) begin
                o_byte_valid  = 1'b1;
                o_rx_byte     = i_state.data_shift;
                o_state.phase = PH_IDLE;
                o_state.armed = 1'b0;
            end else begin
                o_state.phase = PH_IDLE;
                o_state.armed = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/bcd_tone_tracker.sv =====
// Crossing interval measure, period smoothing, tone sums and start detect.
// Depends on bcd_pkg.
module bcd_tone_tracker #(
    parameter int COUNTER_WIDTH = bcd_pkg::COUNTER_WIDTH_DEF
) (
    input  logic [COUNTER_WIDTH-1:0] i_tick,
    input  logic                     i_crossing,
    input  bcd_pkg::t_cfg            i_cfg,
    input  bcd_pkg::t_frame_state    i_state,
    input  logic [COUNTER_WIDTH-1:0] i_deadline,
    input  logic [COUNTER_WIDTH-1:0] i_last_time,
    input  logic [7:0]               i_smoothed,
    output bcd_pkg::t_frame_state    o_state,
    output logic [COUNTER_WIDTH-1:0] o_deadline,
    output logic [COUNTER_WIDTH-1:0] o_last_time,
    output logic [7:0]               o_smoothed
);
    import bcd_pkg::*;

    logic [COUNTER_WIDTH-1:0] interval;
    logic [COUNTER_WIDTH-1:0] smooth_sum;
    logic [7:0]               smooth_new;
    logic [7:0]               low_new;
    logic [7:0]               high_new;

    assign interval   = i_tick - i_last_time;
    assign smooth_sum = (interval >> 1) + (interval >> 2) +
                        COUNTER_WIDTH'(i_smoothed >> 2);
    assign smooth_new = smooth_sum[7:0];
    assign low_new    = i_state.low_sum + smooth_new;
    assign high_new   = i_state.high_sum + smooth_new;

    always_comb begin
        o_state     = i_state;
        o_deadline  = i_deadline;
        o_last_time = i_last_time;
        o_smoothed  = i_smoothed;
        if (i_crossing && (interval >= COUNTER_WIDTH'(i_cfg.min_period))) begin
            o_last_time = i_tick;
            if (interval <= COUNTER_WIDTH'(i_cfg.max_period)) begin
                o_smoothed = smooth_new;
                if (smooth_new >= i_cfg.low_threshold) begin
                    o_state.low_sum = low_new;
                    // Half a bit of low tone while idle opens a frame
                    if ((i_state.phase == PH_IDLE) && (low_new >= (i_cfg.bit_period >> 1))) begin
                        o_state.phase      = PH_START;
                        o_state.high_sum   = '0;
                        o_state.data_shift = '0;
                        o_state.armed      = 1'b1;
                        o_deadline = i_tick + COUNTER_WIDTH'(i_cfg.bit_period) -
                                     COUNTER_WIDTH'(low_new);
                    end
                end else if (smooth_new <= i_cfg.high_threshold) begin
                    // A full bit of high tone while idle flushes both sums
                    if ((i_state.phase == PH_IDLE) && (high_new >= i_cfg.bit_period)) begin
                        o_state.low_sum  = '0;
                        o_state.high_sum = '0;
                    end else begin
                        o_state.high_sum = high_new;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/bfsk_crossing_demodulator_unit.sv =====
// Top level of the BFSK zero-crossing demodulator: handshake, state registers.
// Depends on bcd_pkg, bcd_in_if, bcd_out_if, bcd_bit_slicer, bcd_tone_tracker.
//
//   channel   dir  payload                      meaning
//   i_item    in   crossing                     one counter tick, crossing flag
//   o_result  out  byte_valid, rx_byte[7:0]     one result per tick
//   i_cfg_*   in   we, idx[2:0], data[7:0]      register writes, no read-back
//
// Flow: one request per clock while results are taken; a tick enters the input
// register, the whole tick update is combinational and lands in the result
// register, so throughput is one tick per cycle unless the result stalls.
// Reset: synchronous, active low; restores register defaults, idle framing.
// Stalls: while the result register is held, the input register still takes
// one more tick; the chain then stops until the result is taken.
module bfsk_crossing_demodulator_unit #(
    parameter int COUNTER_WIDTH = bcd_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bcd_in_if.sink                        i_item,
    bcd_out_if.source                     o_result,
    input  logic                          i_cfg_we,
    input  logic [bcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bcd_pkg::*;

    // Configuration
    t_cfg r_cfg;

    // Input register
    logic r_in_valid;
    logic r_crossing;

    // Tick state
    logic [COUNTER_WIDTH-1:0] r_tick;
    logic [COUNTER_WIDTH-1:0] r_last_time;
    logic [COUNTER_WIDTH-1:0] r_deadline;
    logic [7:0]               r_smoothed;
    t_frame_state             r_state;

    // Result register
    logic       r_out_valid;
    logic       r_byte_valid;
    logic [7:0] r_rx_byte;

    // Next-state wires
    t_frame_state             slice_state;
    logic [COUNTER_WIDTH-1:0] slice_deadline;
    logic                     n_byte_valid;
    logic [7:0]               n_rx_byte;
    t_frame_state             n_state;
    logic [COUNTER_WIDTH-1:0] n_deadline;
    logic [COUNTER_WIDTH-1:0] n_last_time;
    logic [7:0]               n_smoothed;

    logic advance;
    logic take_in;

    // Advance the held tick when the result register is free or being drained
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;
    assign take_in        = i_item.valid && i_item.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.byte_valid = r_byte_valid;
    assign o_result.rx_byte    = r_rx_byte;

    // A deadline is served before the crossing of the same tick
    bcd_bit_slicer #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_slicer (
        .i_tick       (r_tick),
        .i_bit_period (r_cfg.bit_period),
        .i_state      (r_state),
        .i_deadline   (r_deadline),
        .o_state      (slice_state),
        .o_deadline   (slice_deadline),
        .o_byte_valid (n_byte_valid),
        .o_rx_byte    (n_rx_byte)
    );

    bcd_tone_tracker #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_tracker (
        .i_tick      (r_tick),
        .i_crossing  (r_crossing),
        .i_cfg       (r_cfg),
        .i_state     (slice_state),
        .i_deadline  (slice_deadline),
        .i_last_time (r_last_time),
        .i_smoothed  (r_smoothed),
        .o_state     (n_state),
        .o_deadline  (n_deadline),
        .o_last_time (n_last_time),
        .o_smoothed  (n_smoothed)
    );

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_period     <= MIN_PERIOD_RST;
            r_cfg.max_period     <= MAX_PERIOD_RST;
            r_cfg.low_threshold  <= LOW_THRESHOLD_RST;
            r_cfg.high_threshold <= HIGH_THRESHOLD_RST;
            r_cfg.bit_period     <= BIT_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_PERIOD:     r_cfg.min_period     <= i_cfg_data;
                REG_MAX_PERIOD:     r_cfg.max_period     <= i_cfg_data;
                REG_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg_data;
                REG_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg_data;
                REG_BIT_PERIOD:     r_cfg.bit_period     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: load on accept, drop once the tick has advanced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_crossing <= i_item.crossing;
        end
    end

    // Tick state: commit the whole update when the tick advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_last_time <= '0;
            r_deadline  <= '0;
            r_smoothed  <= '0;
            r_state     <= '{low_sum: 8'd0, high_sum: 8'd0, phase: PH_IDLE,
                             data_shift: 8'd0, armed: 1'b0};
        end else if (advance) begin
            r_tick      <= r_tick + COUNTER_WIDTH'(1);
            r_last_time <= n_last_time;
            r_deadline  <= n_deadline;
            r_smoothed  <= n_smoothed;
            r_state     <= n_state;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte_valid <= n_byte_valid;
            r_rx_byte    <= n_rx_byte;
        end
    end

    // The deadline is armed exactly while a frame is open
    a_armed_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed == (r_state.phase != PH_IDLE))
        else $error("deadline armed state disagrees with frame phase");

    // Only start, data, stop and idle phases are ever reached
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase <= PH_STOP) || (r_state.phase == PH_IDLE))
        else $error("frame phase left its legal range");

    // A byte leaves only from the stop phase
    a_byte_at_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_byte_valid |-> r_state.phase == PH_STOP)
        else $error("byte emitted outside the stop phase");

    // The tick counter moves only with an advancing tick
    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_tick))
        else $error("tick counter moved without a tick");

    // An empty result carries a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_byte_valid |-> r_rx_byte == 8'd0)
        else $error("rx_byte nonzero without byte_valid");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for bfsk_crossing_demodulator_unit. It feeds counter ticks,
// predicts the unit's tick results and compares each one as it arrives.
// Depends on bcd_pkg, bcd_in_if, bcd_out_if and the unit's RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bcd_pkg::*;

    localparam int CW            = COUNTER_WIDTH_DEF;
    localparam int MAX_WAIT      = 17;   // longest idle either side draws per request
    localparam int LONG_HOLD     = 120;  // sink hold-off that backs the unit up
    localparam int SETTLE_CYCLES = 6;    // margin for the input and result registers to empty
    localparam int DRAIN_LIMIT   = 4000;

    // One tick result as the unit reports it
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
    } tick_result_t;

    // Directed plan row: either a register write or one tick request
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  crossing;
        logic                  typed;      // result written out by hand below
        tick_result_t          typed_res;
    } plan_row_t;

    // Random phase: register setting plus the tone spacings that suit it
    typedef struct packed {
        t_cfg        cfg;
        logic [7:0]  low_iv;
        logic [7:0]  high_iv;
        logic [15:0] ticks;
    } tone_phase_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bcd_in_if  tick_ch ();
    bcd_out_if result_ch ();

    bfsk_crossing_demodulator_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (tick_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Demodulator prediction: own copy of registers, timing and framing
    // ------------------------------------------------------------------
    t_cfg          demod_cfg;
    t_frame_state  demod_frame;
    logic [CW-1:0] tick_count;
    logic [CW-1:0] last_cross;
    logic [CW-1:0] bit_due;
    logic [7:0]    smooth_period;

    tick_result_t  due_results_q [$];   // one entry per accepted tick, oldest first
    logic          crossing_plan_q [$]; // crossing flags waiting to be offered
    int            since_cross;
    int            send_run;
    int            taken_count;
    int            error_count;

    function automatic void demod_reset();
        demod_cfg = '{min_period: MIN_PERIOD_RST, max_period: MAX_PERIOD_RST,
                      low_threshold: LOW_THRESHOLD_RST, high_threshold: HIGH_THRESHOLD_RST,
                      bit_period: BIT_PERIOD_RST};
        demod_frame = '{low_sum: '0, high_sum: '0, phase: PH_IDLE, data_shift: '0,
                        armed: 1'b0};
        tick_count    = '0;
        last_cross    = '0;
        bit_due       = '0;
        smooth_period = '0;
    endfunction

    function automatic void demod_set_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MIN_PERIOD:     demod_cfg.min_period     = val;
            REG_MAX_PERIOD:     demod_cfg.max_period     = val;
            REG_LOW_THRESHOLD:  demod_cfg.low_threshold  = val;
            REG_HIGH_THRESHOLD: demod_cfg.high_threshold = val;
            REG_BIT_PERIOD:     demod_cfg.bit_period     = val;
            default: ;
        endcase
    endfunction

    // Advance one counter tick: serve a due bit deadline, then the crossing.
    function automatic tick_result_t demod_tick(input logic crossing);
        tick_result_t  res;
        logic [CW-1:0] t;
        logic [CW-1:0] gap;
        logic [7:0]    tone;
        logic          to_idle;
        res     = '0;
        to_idle = 1'b0;
        t       = tick_count;
        if (demod_frame.armed && t == bit_due) begin
            bit_due = t + CW'(demod_cfg.bit_period);
            // larger sum wins the bit, low on a tie; lower the winner, saturating at zero
            if (demod_frame.high_sum > demod_frame.low_sum) begin
                demod_frame.high_sum = (demod_frame.high_sum >= demod_cfg.bit_period) ?
                    demod_frame.high_sum - demod_cfg.bit_period : 8'd0;
                tone = TONE_HIGH_BIT;
            end else begin
                demod_frame.low_sum = (demod_frame.low_sum >= demod_cfg.bit_period) ?
                    demod_frame.low_sum - demod_cfg.bit_period : 8'd0;
                tone = 8'd0;
            end
            if (demod_frame.phase == PH_START) begin
                if (tone == 8'd0) begin
                    demod_frame.phase = demod_frame.phase + 4'd1;
                end else begin
                    to_idle = 1'b1;
                end
            end else if (demod_frame.phase <= PH_LAST_DATA) begin
                demod_frame.data_shift = (demod_frame.data_shift >> 1) | tone;
                demod_frame.phase      = demod_frame.phase + 4'd1;
            end else if (demod_frame.phase == PH_STOP) begin
                res.byte_valid = 1'b1;
                res.rx_byte    = demod_frame.data_shift;
                to_idle        = 1'b1;
            end else begin
                to_idle = 1'b1;
            end
            if (to_idle) begin
                demod_frame.phase = PH_IDLE;
                demod_frame.armed = 1'b0;
            end
        end
        if (crossing) begin
            gap = t - last_cross;
            if (gap >= demod_cfg.min_period) begin
                last_cross = t;
                if (gap <= demod_cfg.max_period) begin
                    smooth_period = 8'((32'(gap) >> 1) + (32'(gap) >> 2) +
                                       (32'(smooth_period) >> 2));
                    if (smooth_period >= demod_cfg.low_threshold) begin
                        demod_frame.low_sum = demod_frame.low_sum + smooth_period;
                        if (demod_frame.phase == PH_IDLE &&
                            demod_frame.low_sum >= (demod_cfg.bit_period >> 1)) begin
                            demod_frame.phase      = PH_START;
                            demod_frame.high_sum   = '0;
                            demod_frame.data_shift = '0;
                            bit_due = t + CW'(demod_cfg.bit_period) - CW'(demod_frame.low_sum);
                            demod_frame.armed      = 1'b1;
                        end
                    end else if (smooth_period <= demod_cfg.high_threshold) begin
                        demod_frame.high_sum = demod_frame.high_sum + smooth_period;
                        if (demod_frame.phase == PH_IDLE &&
                            demod_frame.high_sum >= demod_cfg.bit_period) begin
                            demod_frame.low_sum  = '0;
                            demod_frame.high_sum = '0;
                        end
                    end
                end
            end
        end
        tick_count = t + CW'(1);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus shaping
    // ------------------------------------------------------------------

    // Idle cycles before the next request; now and then a run with no idling.
    function automatic int pick_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            run_left = $urandom_range(16, 48);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Append a tone: a crossing every interval ticks, with a little jitter.
    function automatic void add_tone(input int interval, input int span);
        for (int k = 0; k < span; k++) begin
            since_cross++;
            if (since_cross >= interval) begin
                crossing_plan_q.push_back(1'b1);
                since_cross = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
            end else begin
                crossing_plan_q.push_back(1'b0);
            end
        end
    endfunction

    function automatic void add_noise(input int span);
        int density;
        density = $urandom_range(1, 4);
        for (int k = 0; k < span; k++) begin
            crossing_plan_q.push_back($urandom_range(1, density * 2) == 1);
        end
    endfunction

    // Mark, start, data bits LSB first, stop; a broken frame may stop early, then noise.
    function automatic void add_frame(input int low_iv, input int high_iv, input int bit_len,
                                      input logic broken);
        logic [7:0] data;
        int         n_bits;
        data   = $urandom_range(0, 255);
        n_bits = broken ? $urandom_range(0, 8) : 8;
        add_tone(high_iv, bit_len * $urandom_range(1, 2));
        add_tone(low_iv, bit_len);
        for (int b = 0; b < n_bits; b++) begin
            add_tone(data[b] ? high_iv : low_iv, bit_len);
        end
        if (broken) begin
            add_noise($urandom_range(1, bit_len));
        end else begin
            add_tone(high_iv, bit_len);
        end
    endfunction

    function automatic plan_row_t quiet_tick(input logic c);
        return '{is_write: 1'b0, reg_idx: '0, reg_val: '0, crossing: c, typed: 1'b1,
                 typed_res: '0};
    endfunction

    function automatic plan_row_t tick_row(input logic c);
        return '{is_write: 1'b0, reg_idx: '0, reg_val: '0, crossing: c, typed: 1'b0,
                 typed_res: '0};
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        return '{is_write: 1'b1, reg_idx: idx, reg_val: val, crossing: 1'b0, typed: 1'b0,
                 typed_res: '0};
    endfunction

    // Directed plan. Quiet ticks are those where no frame can be armed, so
    // the result is plainly all zero: noise below the minimum, restarts.
    plan_row_t directed_rows [35] = '{
        quiet_tick(1'b0), quiet_tick(1'b1), quiet_tick(1'b1),
        // every interval counts as noise
        reg_row(REG_MIN_PERIOD, 8'd255), quiet_tick(1'b1),
        // every interval only restarts timing
        reg_row(REG_MIN_PERIOD, 8'd0), reg_row(REG_MAX_PERIOD, 8'd0),
        reg_row(REG_LOW_THRESHOLD, 8'd255), reg_row(REG_HIGH_THRESHOLD, 8'd0),
        reg_row(REG_BIT_PERIOD, 8'd255), quiet_tick(1'b1), quiet_tick(1'b1),
        // wide open window, zero bit period: start detect always passes
        reg_row(REG_MAX_PERIOD, 8'd255), reg_row(REG_LOW_THRESHOLD, 8'd0),
        reg_row(REG_HIGH_THRESHOLD, 8'd255), reg_row(REG_BIT_PERIOD, 8'd0),
        tick_row(1'b1), tick_row(1'b1), tick_row(1'b1), tick_row(1'b0),
        tick_row(1'b1), tick_row(1'b0), tick_row(1'b0), tick_row(1'b1),
        // one-tick bits: deadlines come every tick, bytes end quickly
        reg_row(REG_BIT_PERIOD, 8'd1),
        tick_row(1'b1), tick_row(1'b0), tick_row(1'b1), tick_row(1'b1), tick_row(1'b0),
        tick_row(1'b0), tick_row(1'b1), tick_row(1'b1), tick_row(1'b1), tick_row(1'b0)
    };

    // Random phases: min, max, low thr, high thr, bit period; low/high spacing; ticks
    tone_phase_t phase_rows [6] = '{
        '{'{8'd1,   8'd5,   8'd2,   8'd1,   8'd6},   8'd4,  8'd2,  16'd180},
        '{'{8'd2,   8'd12,  8'd6,   8'd4,   8'd16},  8'd8,  8'd4,  16'd180},
        '{'{8'd2,   8'd14,  8'd9,   8'd6,   8'd20},  8'd12, 8'd6,  16'd90},
        '{'{8'd0,   8'd255, 8'd0,   8'd255, 8'd1},   8'd2,  8'd1,  16'd60},
        '{'{8'd255, 8'd0,   8'd255, 8'd0,   8'd255}, 8'd3,  8'd1,  16'd30},
        '{'{MIN_PERIOD_RST, MAX_PERIOD_RST, LOW_THRESHOLD_RST, HIGH_THRESHOLD_RST,
            BIT_PERIOD_RST}, 8'd50, 8'd20, 16'd40}
    };

    // ------------------------------------------------------------------
    // Request drivers
    // ------------------------------------------------------------------

    // Offer one tick request; predict its result once it is accepted.
    task automatic offer_tick(input logic crossing, input logic typed,
                              input tick_result_t typed_res);
        int           idle;
        tick_result_t res;
        idle = pick_wait(send_run);
        if (idle > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        tick_ch.valid    <= 1'b1;
        tick_ch.crossing <= crossing;
        do @(posedge i_clk); while (!tick_ch.ready);
        // advance the prediction even where the result is typed in
        res = demod_tick(crossing);
        due_results_q.push_back(typed ? typed_res : res);
    endtask

    // Write a register only once every pending result is back and the
    // pipeline has had time to empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        tick_ch.valid <= 1'b0;
        while (due_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        demod_set_reg(idx, val);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, directed plan, random phases, drain, verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        int sent;
        int kind;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        tick_ch.valid    <= 1'b0;
        tick_ch.crossing <= 1'b0;
        since_cross = 0;
        send_run    = 0;
        error_count = 0;
        demod_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_write) begin
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                offer_tick(directed_rows[r].crossing, directed_rows[r].typed,
                           directed_rows[r].typed_res);
            end
        end

        // Random phases: mostly whole frames with random bytes, some broken
        // frames and bursts of noise; cut each phase at its tick budget.
        foreach (phase_rows[p]) begin
            write_reg(REG_MIN_PERIOD,     phase_rows[p].cfg.min_period);
            write_reg(REG_MAX_PERIOD,     phase_rows[p].cfg.max_period);
            write_reg(REG_LOW_THRESHOLD,  phase_rows[p].cfg.low_threshold);
            write_reg(REG_HIGH_THRESHOLD, phase_rows[p].cfg.high_threshold);
            write_reg(REG_BIT_PERIOD,     phase_rows[p].cfg.bit_period);
            sent = 0;
            while (sent < int'(phase_rows[p].ticks)) begin
                kind = $urandom_range(0, 9);
                if (kind <= 7) begin
                    add_frame(phase_rows[p].low_iv, phase_rows[p].high_iv,
                              phase_rows[p].cfg.bit_period, kind == 7);
                end else begin
                    add_noise($urandom_range(4, 30));
                end
                while (crossing_plan_q.size() != 0 && sent < int'(phase_rows[p].ticks)) begin
                    offer_tick(crossing_plan_q.pop_front(), 1'b0, '0);
                    sent++;
                end
                crossing_plan_q.delete();
            end
        end

        // Stop offering, let every result come home
        tick_ch.valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && due_results_q.size() != 0; w++) begin
            @(posedge i_clk);
        end
        if (due_results_q.size() != 0) begin
            $error("tick results never arrived: %0d still pending", due_results_q.size());
            error_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: random hold-offs, two long ones to back the unit up
    // ------------------------------------------------------------------
    initial begin : result_sink
        int           hold;
        int           run_left;
        tick_result_t want;
        run_left        = 0;
        taken_count     = 0;
        result_ch.ready <= 1'b0;
        // wait for a known, released reset before taking anything
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            // hold off long enough that the unit fills and stalls the sender
            if (taken_count == 200 || taken_count == 470) begin
                hold = LONG_HOLD;
            end else begin
                hold = pick_wait(run_left);
            end
            if (hold > 0) begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            taken_count++;
            if (due_results_q.size() == 0) begin
                $error("result with no tick pending: byte_valid=%0b rx_byte=%02h",
                       result_ch.byte_valid, result_ch.rx_byte);
                error_count++;
            end else begin
                want = due_results_q.pop_front();
                if (result_ch.byte_valid !== want.byte_valid) begin
                    $error("byte_valid: expected %0b, got %0b",
                           want.byte_valid, result_ch.byte_valid);
                    error_count++;
                end
                if (result_ch.rx_byte !== want.rx_byte) begin
                    $error("rx_byte: expected %02h, got %02h",
                           want.rx_byte, result_ch.rx_byte);
                    error_count++;
                end
            end
        end
    end

    // Hard stop if the handshakes hang
    initial begin : watchdog
        #4ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bcd_pkg.sv
rtl/bcd_in_if.sv
rtl/bcd_out_if.sv
rtl/bcd_bit_slicer.sv
rtl/bcd_tone_tracker.sv
rtl/bfsk_crossing_demodulator_unit.sv
verif/tb_top.sv
